// File: src/qdpr_pkg.sv
// Shared types and constants for the quantized dot-product requantization unit.
`timescale 1ns / 1ps

package qdpr_pkg;

  localparam int DataW = 8;
  localparam int BnW   = 32;
  localparam int ProdW = 17;

  typedef struct packed {
    logic [15:0] mult;
    logic [4:0]  shift;
    logic        relu;
    logic        bn;
  } qdpr_cfg_t;

endpackage

// File: src/qdpr_fifo.sv
// Two-entry queue carrying finished channel sums from the MAC front to the requantizer.
`timescale 1ns / 1ps

module qdpr_fifo #(
  parameter int WIDTH = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int Depth = 2;

  logic [WIDTH-1:0] mem_q [Depth];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o  = (count_q == 2'(Depth));
  assign empty_o = (count_q == 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(Depth)) else $error("queue count out of range");

endmodule

// File: src/qdpr_front.sv
// MAC front end: accumulates both columns and queues the sums on the last element.
`timescale 1ns / 1ps

module qdpr_front #(
  parameter int ACC_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [qdpr_pkg::DataW-1:0] weight_i,
  input  logic [qdpr_pkg::DataW-1:0]       act_first_i,
  input  logic [qdpr_pkg::DataW-1:0]       act_second_i,
  input  logic signed [qdpr_pkg::DataW-1:0] bias_i,
  input  logic signed [qdpr_pkg::BnW-1:0]  bn_scale_i,
  input  logic signed [qdpr_pkg::BnW-1:0]  bn_offset_i,
  input  logic                             first_element_i,
  input  logic                             last_element_i,
  input  logic                             full_i,
  output logic                             push_o,
  output logic [2*ACC_WIDTH+2*qdpr_pkg::BnW-1:0] job_o
);

  localparam int PW = qdpr_pkg::ProdW;
  localparam int DW = qdpr_pkg::DataW;

  logic [ACC_WIDTH-1:0] acc_first_q, acc_first_d;
  logic [ACC_WIDTH-1:0] acc_second_q, acc_second_d;
  logic signed [PW-1:0] prod_first, prod_second;
  logic [ACC_WIDTH-1:0] bias_ext, base_first, base_second;
  logic                 accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  assign prod_first  = weight_i * $signed({1'b0, act_first_i});
  assign prod_second = weight_i * $signed({1'b0, act_second_i});
  assign bias_ext    = {{(ACC_WIDTH-DW){bias_i[DW-1]}}, bias_i};

  // Reload from bias on the first element, otherwise keep summing.
  assign base_first  = first_element_i ? bias_ext : acc_first_q;
  assign base_second = first_element_i ? bias_ext : acc_second_q;

  assign acc_first_d  = base_first + {{(ACC_WIDTH-PW){prod_first[PW-1]}}, prod_first};
  assign acc_second_d = base_second + {{(ACC_WIDTH-PW){prod_second[PW-1]}}, prod_second};

  assign push_o = accept && last_element_i;
  assign job_o  = {acc_second_d, acc_first_d, bn_offset_i, bn_scale_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_first_q  <= '0;
      acc_second_q <= '0;
    end else if (accept) begin
      acc_first_q  <= acc_first_d;
      acc_second_q <= acc_second_d;
    end
  end

endmodule

// File: src/qdpr_back.sv
// Requantizer: shared multiplier over three partial products, offset, shift and clip.
`timescale 1ns / 1ps

module qdpr_back #(
  parameter int ACC_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  qdpr_pkg::qdpr_cfg_t      cfg_i,
  input  logic                     empty_i,
  input  logic [2*ACC_WIDTH+2*qdpr_pkg::BnW-1:0] job_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [qdpr_pkg::DataW-1:0] out_first_o,
  output logic [qdpr_pkg::DataW-1:0] out_second_o
);

  localparam int BW    = qdpr_pkg::BnW;
  localparam int DW    = qdpr_pkg::DataW;
  localparam int HalfW = (ACC_WIDTH + 1) / 2;
  localparam int FullW = 2 * HalfW;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul0 = 3'd1;
  localparam logic [2:0] StMul1 = 3'd2;
  localparam logic [2:0] StMul2 = 3'd3;
  localparam logic [2:0] StAdd  = 3'd4;
  localparam logic [2:0] StClip = 3'd5;
  localparam logic [2:0] StHold = 3'd6;

  logic [2:0]           state_q, state_d;
  logic                 col_q, col_d;
  logic                 out_valid_q, out_valid_d;
  logic [ACC_WIDTH-1:0] acc_first_q, acc_second_q;
  logic [BW-1:0]        kappa_q, lambda_q;
  logic [FullW-1:0]     prod_q;
  logic [ACC_WIDTH-1:0] val_q;
  logic [DW-1:0]        res_first_q;
  logic [DW-1:0]        res_second_q;
  logic [DW-1:0]        out_first_q, out_second_q;

  logic                 bn_mode;
  logic [63:0]          kappa_ext, lambda_ext;
  logic [ACC_WIDTH-1:0] sum_sel, mul_op, addend;
  logic [FullW-1:0]     s_pad, m_pad, mul_p, mul_sh;
  logic [HalfW-1:0]     mul_a, mul_b;
  logic signed [ACC_WIDTH-1:0] shifted;
  logic [DW-1:0]        clipped;
  logic                 load_out;

  assign bn_mode    = cfg_i.relu && cfg_i.bn;
  assign kappa_ext  = {{(64-BW){kappa_q[BW-1]}}, kappa_q};
  assign lambda_ext = {{(64-BW){lambda_q[BW-1]}}, lambda_q};
  assign sum_sel    = col_q ? acc_second_q : acc_first_q;

  always_comb begin
    if (bn_mode) begin
      mul_op = kappa_ext[ACC_WIDTH-1:0];
    end else if (cfg_i.relu) begin
      mul_op = ACC_WIDTH'(cfg_i.mult);
    end else begin
      mul_op = ACC_WIDTH'(1);
    end
  end

  assign addend = bn_mode ? lambda_ext[ACC_WIDTH-1:0] : '0;
  assign s_pad  = FullW'(sum_sel);
  assign m_pad  = FullW'(mul_op);

  // Low x low, low x high, high x low; the high x high term falls off the top.
  assign mul_a  = (state_q == StMul2) ? s_pad[FullW-1:HalfW] : s_pad[HalfW-1:0];
  assign mul_b  = (state_q == StMul1) ? m_pad[FullW-1:HalfW] : m_pad[HalfW-1:0];
  assign mul_p  = FullW'(mul_a) * FullW'(mul_b);
  assign mul_sh = mul_p << HalfW;

  assign shifted = $signed(val_q) >>> cfg_i.shift;

  always_comb begin
    if (shifted[ACC_WIDTH-1]) begin
      clipped = '0;
    end else if (shifted[ACC_WIDTH-2:DW] != '0) begin
      clipped = {DW{1'b1}};
    end else begin
      clipped = shifted[DW-1:0];
    end
  end

  assign load_out = (state_q == StHold) && (!out_valid_q || !out_stall_i);
  assign pop_o    = (state_q == StIdle) && !empty_i;

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (!empty_i) begin
          state_d = StMul0;
          col_d   = 1'b0;
        end
      end
      StMul0: state_d = StMul1;
      StMul1: state_d = StMul2;
      StMul2: state_d = StAdd;
      StAdd:  state_d = StClip;
      StClip: begin
        if (col_q) begin
          state_d = StHold;
        end else begin
          state_d = StMul0;
          col_d   = 1'b1;
        end
      end
      StHold: begin
        if (load_out) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      col_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      {acc_second_q, acc_first_q, lambda_q, kappa_q} <= job_i;
    end
    case (state_q)
      StMul0: prod_q <= mul_p;
      StMul1, StMul2: prod_q <= prod_q + mul_sh;
      StAdd:  val_q  <= prod_q[ACC_WIDTH-1:0] + addend;
      StClip: begin
        if (col_q) begin
          res_second_q <= clipped;
        end else begin
          res_first_q <= clipped;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_first_q  <= res_first_q;
      out_second_q <= res_second_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_first_o  = out_first_q;
  assign out_second_o = out_second_q;

  a_mul_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMul0 |=> state_q == StMul1) else $error("multiply sequence broken");
  a_mul_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMul2 |=> state_q == StAdd) else $error("offset step skipped");
  a_hold_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StHold |-> col_q) else $error("result held before second column");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == StMul0 && !col_q) else $error("job taken outside idle");

endmodule

// File: src/quantized_dot_product_requant_unit.sv
// Top level: configuration registers, MAC front end, job queue and requantizer.
`timescale 1ns / 1ps

// Input items are taken one per cycle while the queue has room; an item that
// is not marked last only updates the two accumulators. An item marked last
// queues both sums into a two-entry queue, and the requantizer turns each
// queued pair into one output item: it takes the job in StIdle, then per
// column runs StMul0, StMul1 and StMul2 on one shared half-width multiplier
// (the sum times kappa, the multiplier or one, by mode), StAdd to add lambda
// in batch-norm mode and StClip to shift and clip, and finally loads the
// output register in StHold.
// The input side stalls only while the queue is full. The output register lets
// the requantizer finish the next item while a result waits to be taken.
// Registers sit at byte offsets 0x0 multiplier, 0x4 shift, 0x8 ReLU enable,
// 0xC batch-norm enable; write them only while the unit is idle.
module quantized_dot_product_requant_unit #(
  parameter int ACC_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic signed [7:0]  weight_i,
  input  logic [7:0]         act_first_i,
  input  logic [7:0]         act_second_i,
  input  logic signed [7:0]  bias_i,
  input  logic signed [31:0] bn_scale_i,
  input  logic signed [31:0] bn_offset_i,
  input  logic        first_element_i,
  input  logic        last_element_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_first_o,
  output logic [7:0]  out_second_o
);

  localparam int JobW = 2 * ACC_WIDTH + 2 * qdpr_pkg::BnW;

  localparam logic [1:0] RegMult  = 2'd0;
  localparam logic [1:0] RegShift = 2'd1;
  localparam logic [1:0] RegRelu  = 2'd2;
  localparam logic [1:0] RegBn    = 2'd3;

  qdpr_pkg::qdpr_cfg_t cfg_q;
  logic                cfg_we;
  logic [1:0]          reg_idx;

  logic            push, pop, full, empty;
  logic [JobW-1:0] job_in, job_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mult  <= 16'd1;
      cfg_q.shift <= '0;
      cfg_q.relu  <= 1'b0;
      cfg_q.bn    <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx)
        RegMult:  cfg_q.mult  <= pwdata[15:0];
        RegShift: cfg_q.shift <= pwdata[4:0];
        RegRelu:  cfg_q.relu  <= pwdata[0];
        RegBn:    cfg_q.bn    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegMult:  prdata = {16'd0, cfg_q.mult};
      RegShift: prdata = {27'd0, cfg_q.shift};
      RegRelu:  prdata = {31'd0, cfg_q.relu};
      RegBn:    prdata = {31'd0, cfg_q.bn};
      default:  prdata = '0;
    endcase
  end

  qdpr_front #(
    .ACC_WIDTH(ACC_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .weight_i       (weight_i),
    .act_first_i    (act_first_i),
    .act_second_i   (act_second_i),
    .bias_i         (bias_i),
    .bn_scale_i     (bn_scale_i),
    .bn_offset_i    (bn_offset_i),
    .first_element_i(first_element_i),
    .last_element_i (last_element_i),
    .full_i         (full),
    .push_o         (push),
    .job_o          (job_in)
  );

  qdpr_fifo #(
    .WIDTH(JobW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(job_in),
    .pop_i  (pop),
    .rdata_o(job_out),
    .full_o (full),
    .empty_o(empty)
  );

  qdpr_back #(
    .ACC_WIDTH(ACC_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_first_o (out_first_o),
    .out_second_o(out_second_o)
  );

endmodule

// File: tb/tb_quantized_dot_product_requant_unit.sv
// Testbench for the quantized dot-product requantization unit: directed and random channels.
`timescale 1ns / 1ps

module tb_quantized_dot_product_requant_unit;

  localparam logic [3:0] MultAddr  = 4'h0;
  localparam logic [3:0] ShiftAddr = 4'h4;
  localparam logic [3:0] ReluAddr  = 4'h8;
  localparam logic [3:0] BnAddr    = 4'hC;

  localparam int DrainCycles   = 40;
  localparam int LongHold      = 400;
  localparam int WatchdogLimit = 4000;

  typedef struct {
    logic signed [7:0]  weight;
    logic [7:0]         act_first;
    logic [7:0]         act_second;
    logic signed [7:0]  bias;
    logic signed [31:0] kappa;
    logic signed [31:0] lambda;
    logic               first;
    logic               last;
  } mac_item_t;

  typedef struct {
    logic [7:0] first;
    logic [7:0] second;
  } byte_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [7:0] weight_i = '0;
  logic [7:0] act_first_i = '0;
  logic [7:0] act_second_i = '0;
  logic signed [7:0] bias_i = '0;
  logic signed [31:0] bn_scale_i = '0;
  logic signed [31:0] bn_offset_i = '0;
  logic first_element_i = 1'b0;
  logic last_element_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] out_first_o;
  logic [7:0] out_second_o;

  qdpr_pkg::qdpr_cfg_t active_cfg = '{mult: 16'd1, shift: 5'd0, relu: 1'b0, bn: 1'b0};
  logic signed [31:0] sum_first = '0;
  logic signed [31:0] sum_second = '0;
  byte_pair_t expected_bytes[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;
  logic hold_output_req = 1'b0;

  quantized_dot_product_requant_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .weight_i        (weight_i),
    .act_first_i     (act_first_i),
    .act_second_i    (act_second_i),
    .bias_i          (bias_i),
    .bn_scale_i      (bn_scale_i),
    .bn_offset_i     (bn_offset_i),
    .first_element_i (first_element_i),
    .last_element_i  (last_element_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_first_o     (out_first_o),
    .out_second_o    (out_second_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [7:0] requantize_sum(input logic signed [31:0] sum,
                                                input logic signed [31:0] kappa,
                                                input logic signed [31:0] lambda);
    logic signed [31:0] scaled;
    logic signed [31:0] shifted;
    // batch norm only counts together with ReLU
    if (active_cfg.relu && active_cfg.bn) begin
      scaled = sum * kappa + lambda;
    end else if (active_cfg.relu) begin
      scaled = sum * $signed({16'd0, active_cfg.mult});
    end else begin
      scaled = sum;
    end
    shifted = scaled >>> active_cfg.shift;
    if (shifted < 0) return 8'd0;
    if (shifted > 255) return 8'd255;
    return shifted[7:0];
  endfunction

  task automatic accumulate_item(input mac_item_t item);
    byte_pair_t pair;
    if (item.first) begin
      sum_first = item.bias;
      sum_second = item.bias;
    end
    sum_first = sum_first + item.weight * $signed({1'b0, item.act_first});
    sum_second = sum_second + item.weight * $signed({1'b0, item.act_second});
    if (item.last) begin
      pair.first = requantize_sum(sum_first, item.kappa, item.lambda);
      pair.second = requantize_sum(sum_second, item.kappa, item.lambda);
      expected_bytes.push_back(pair);
    end
  endtask

  function automatic mac_item_t make_item(input logic signed [7:0] weight,
                                          input logic [7:0] act_first,
                                          input logic [7:0] act_second,
                                          input logic signed [7:0] bias,
                                          input logic signed [31:0] kappa,
                                          input logic signed [31:0] lambda,
                                          input logic first, input logic last);
    mac_item_t item;
    item.weight = weight;
    item.act_first = act_first;
    item.act_second = act_second;
    item.bias = bias;
    item.kappa = kappa;
    item.lambda = lambda;
    item.first = first;
    item.last = last;
    return item;
  endfunction

  function automatic mac_item_t random_item(input logic first, input logic last);
    mac_item_t item;
    int centered;
    item = make_item(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     $urandom, $urandom, first, last);
    // keep kappa and lambda small half the time so that more outputs land inside 0..255
    if ($urandom_range(0, 1) == 0) begin
      centered = $urandom_range(0, 2047);
      item.kappa = centered - 1024;
      centered = $urandom_range(0, 8191);
      item.lambda = centered - 4096;
    end
    return item;
  endfunction

  task automatic send_item(input mac_item_t item);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    weight_i        <= item.weight;
    act_first_i     <= item.act_first;
    act_second_i    <= item.act_second;
    bias_i          <= item.bias;
    bn_scale_i      <= item.kappa;
    bn_offset_i     <= item.lambda;
    first_element_i <= item.first;
    last_element_i  <= item.last;
    do @(posedge clk_i); while (in_stall_o);
    accumulate_item(item);
  endtask

  // drop valid and wait until every result is out and the requantizer is quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [3:0] addr, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (addr)
      MultAddr:  active_cfg.mult = value[15:0];
      ShiftAddr: active_cfg.shift = value[4:0];
      ReluAddr:  active_cfg.relu = value[0];
      BnAddr:    active_cfg.bn = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] mult, input logic [4:0] shift,
                            input logic relu, input logic bn);
    settle();
    write_register(MultAddr, {16'd0, mult});
    write_register(ShiftAddr, {27'd0, shift});
    write_register(ReluAddr, {31'd0, relu});
    write_register(BnAddr, {31'd0, bn});
  endtask

  task automatic test_reset_defaults();
    // no first mark right after reset: sums start from zero
    send_item(make_item(8'sd127, 8'd255, 8'd0, 8'sd0, 0, 0, 1'b0, 1'b1));
    send_item(make_item(-8'sd128, 8'd255, 8'd1, 8'sd127, 0, 0, 1'b1, 1'b1));
    send_item(make_item(8'sd1, 8'd100, 8'd5, -8'sd128, 0, 0, 1'b1, 1'b0));
    send_item(make_item(8'sd2, 8'd3, 8'd200, 8'sd0, 0, 0, 1'b0, 1'b0));
    send_item(make_item(-8'sd1, 8'd0, 8'd0, 8'sd0, 0, 0, 1'b0, 1'b1));
    send_item(make_item(8'sd1, 8'd40, 8'd255, -8'sd128, 0, 0, 1'b1, 1'b1));
    // continue the previous sums
    send_item(make_item(8'sd1, 8'd10, 8'd0, 8'sd5, 0, 0, 1'b0, 1'b1));
  endtask

  task automatic test_relu_multiplier();
    set_config(16'hFFFF, 5'd31, 1'b1, 1'b0);
    send_item(make_item(8'sd127, 8'd255, 8'd0, 8'sd127, 0, 0, 1'b1, 1'b1));
    send_item(make_item(-8'sd128, 8'd255, 8'd255, -8'sd128, 0, 0, 1'b1, 1'b1));
    set_config(16'd0, 5'd0, 1'b1, 1'b0);
    send_item(make_item(8'sd100, 8'd200, 8'd7, 8'sd3, 0, 0, 1'b1, 1'b1));
    set_config(16'd3, 5'd2, 1'b1, 1'b0);
    send_item(make_item(8'sd9, 8'd30, 8'd2, -8'sd4, 0, 0, 1'b1, 1'b0));
    send_item(make_item(8'sd1, 8'd11, 8'd60, 8'sd0, 0, 0, 1'b0, 1'b1));
  endtask

  task automatic test_batchnorm();
    set_config(16'd1, 5'd0, 1'b1, 1'b1);
    send_item(make_item(8'sd1, 8'd1, 8'd2, 8'sd0, 32'sh8000_0000, 32'sh7FFF_FFFF,
                        1'b1, 1'b1));
    send_item(make_item(8'sd1, 8'd1, 8'd0, 8'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000,
                        1'b1, 1'b1));
    send_item(make_item(8'sd3, 8'd20, 8'd40, 8'sd1, 32'sd0, 32'sd0, 1'b1, 1'b0));
    send_item(make_item(-8'sd2, 8'd5, 8'd9, 8'sd0, 32'sd2, -32'sd30, 1'b0, 1'b1));
    set_config(16'd1, 5'd31, 1'b1, 1'b1);
    send_item(make_item(8'sd127, 8'd255, 8'd1, 8'sd127, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                        1'b1, 1'b1));
  endtask

  task automatic test_batchnorm_ignored_without_relu();
    set_config(16'd5, 5'd1, 1'b0, 1'b1);
    send_item(make_item(8'sd2, 8'd50, 8'd255, 8'sd0, 32'sd0, 32'sd77, 1'b1, 1'b1));
    send_item(make_item(-8'sd3, 8'd40, 8'd1, 8'sd10, -32'sd1, 32'sd0, 1'b1, 1'b1));
  endtask

  task automatic test_output_hold_and_drain();
    set_config(16'd1, 5'd4, 1'b0, 1'b0);
    no_idle = 1'b1;
    hold_output_req <= 1'b1;
    // keep offering single-element channels while the output is held
    repeat (30) send_item(random_item(1'b1, 1'b1));
    no_idle = 1'b0;
    // pause the sender until everything is out
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (6) begin
      send_item(random_item(1'b1, 1'b0));
      send_item(random_item(1'b0, 1'b1));
    end
  endtask

  task automatic test_random_channels();
    int sent;
    int length;
    logic [15:0] mult;
    logic [4:0] shift;
    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 3))
        0: mult = 16'd0;
        1: mult = 16'd1;
        2: mult = 16'hFFFF;
        default: mult = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: shift = 5'd0;
        1: shift = 5'd31;
        default: shift = 5'($urandom_range(0, 12));
      endcase
      set_config(mult, shift, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      no_idle = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < 100) begin
        if ($urandom_range(0, 9) == 0) begin
          // loose marks: missing first, repeated first, stray last
          send_item(random_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
          sent++;
        end else begin
          length = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
          for (int idx = 0; idx < length; idx++) begin
            send_item(random_item(idx == 0, idx == length - 1));
          end
          sent += length;
        end
      end
      no_idle = 1'b0;
    end
  endtask

  // output side: random stall per item, plus one long hold on request
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_output_req) begin
        hold = LongHold;
        hold_output_req <= 1'b0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 15);
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o && !hold_output_req);
    end
  end

  always @(posedge clk_i) begin
    byte_pair_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result out_first %0d out_second %0d",
                 $time, out_first_o, out_second_o);
        mismatch_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_first_o !== want.first) begin
          $display("%0t: out_first expected %0d actual %0d", $time, want.first, out_first_o);
          mismatch_count++;
        end
        if (out_second_o !== want.second) begin
          $display("%0t: out_second expected %0d actual %0d",
                   $time, want.second, out_second_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, WatchdogLimit);
        $display("tb_quantized_dot_product_requant_unit failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_relu_multiplier();
    test_batchnorm();
    test_batchnorm_ignored_without_relu();
    test_output_hold_and_drain();
    test_random_channels();
    settle();
    if (mismatch_count == 0) begin
      $display("tb_quantized_dot_product_requant_unit passed");
    end else begin
      $display("tb_quantized_dot_product_requant_unit failed");
    end
    $finish;
  end

endmodule
